>>> hw/rtl/pressure_temperature_compensation_assert.svh
// Assertion macros for the pressure/temperature compensation block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`ifndef SYNTH
`define PTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ptc assertion failed");
`define PTC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("ptc forbidden condition");
`else
`define PTC_ASSERT(lbl, prop)
`define PTC_ASSERT_NEVER(lbl, expr)
`endif
`endif

>>> hw/rtl/ptc_pkg.sv
// Shared types, constants and helpers for the compensation block.
// No dependencies.
package ptc_pkg;

  localparam int unsigned DIV_STEPS = 32;

  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] K_SQ        = 32'd3038;
  localparam logic [31:0] K_LIN       = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] K_ROUND     = 32'd3791;
  localparam logic [31:0] OSS_SCALE   = 32'd50000;
  localparam logic [31:0] B4_BIAS     = 32'd32768;
  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;

  localparam logic [1:0] FAULT_OK    = 2'd0;
  localparam logic [1:0] FAULT_TEMP  = 2'd1;
  localparam logic [1:0] FAULT_PRESS = 2'd2;

  localparam logic [1:0] REG_CAL_T  = 2'd0;
  localparam logic [1:0] REG_CAL_PL = 2'd1;
  localparam logic [1:0] REG_CAL_PS = 2'd2;
  localparam logic [1:0] REG_OSS    = 2'd3;

  typedef logic signed [27:0] temp_t;
  typedef logic signed [31:0] press_t;

  // Sideband alongside the temperature divider.
  typedef struct packed {
    logic [31:0] x1;
    logic [18:0] up;
    logic        f1;
    logic        neg;
  } sb_temp_t;

  // Sideband alongside the pressure divider.
  typedef struct packed {
    logic [31:0] b5;
    logic        f1;
    logic        f2;
    logic        post;
  } sb_press_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    asr = 32'($signed(x) >>> n);
  endfunction

endpackage

>>> hw/rtl/ptc_if.sv
// Word channels of the compensation block (valid/ready handshake).
// Depends on ptc_pkg for the result field types.
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [18:0] raw_pressure;
  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface ptc_out_if;
  logic            valid;
  logic            ready;
  ptc_pkg::temp_t  temperature_tenths;
  ptc_pkg::press_t pressure_pa;
  logic [1:0]      fault_code;
  modport source (output valid, output temperature_tenths, output pressure_pa,
                  output fault_code, input ready);
  modport sink   (input valid, input temperature_tenths, input pressure_pa,
                  input fault_code, output ready);
endinterface

>>> hw/rtl/ptc_div.sv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on ptc_pkg for the stage count.
module ptc_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [31:0] quotient_o
);

  // acc holds {remainder, dividend bits still to go / quotient bits so far}
  logic [63:0] acc_q [ptc_pkg::DIV_STEPS];
  logic [31:0] dvs_q [ptc_pkg::DIV_STEPS];
  logic [63:0] acc_d [ptc_pkg::DIV_STEPS];

  for (genvar k = 0; k < ptc_pkg::DIV_STEPS; k++) begin : g_step
    logic [63:0] prev;
    logic [31:0] dvs;
    logic [64:0] sh;
    logic [32:0] trial;
    if (k == 0) begin : g_first
      assign prev = {32'd0, dividend_i};
      assign dvs  = divisor_i;
    end else begin : g_rest
      assign prev = acc_q[k-1];
      assign dvs  = dvs_q[k-1];
    end
    always_comb begin
      sh    = {prev, 1'b0};
      trial = sh[64:32] - {1'b0, dvs};
      if (!trial[32]) begin
        acc_d[k] = {trial[31:0], sh[31:1], 1'b1};
      end else begin
        acc_d[k] = {sh[63:32], sh[31:1], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k] <= acc_d[k];
        dvs_q[k] <= dvs;
      end
    end
  end

  assign quotient_o = acc_q[ptc_pkg::DIV_STEPS-1][31:0];

endmodule

>>> hw/rtl/pressure_temperature_compensation.sv
// Integer barometric compensation: raw temperature/pressure word in, compensated word out.
// Top level; depends on ptc_pkg, ptc_if, ptc_div and the assertion header.
//
// Usage: in_i takes one word per cycle unless out_o stalls (raw temperature and
// raw pressure); out_o gives one word per input (temperature in 0.1 degC,
// pressure in Pa, fault code). Calibration words and the oversampling setting are
// written through the APB port at byte addresses 0, 8, 16 and 24; write them only
// while no word is in flight.
// The path from in_i to out_o runs through two 32-stage dividers (temperature
// divisor, then pressure divisor) plus the multiply and add stages around them.
// Throughput: one word per cycle unless out_o stalls; every stage advances together.
// Reset clears all stage valid bits and loads the register reset values
// (calibration zero, oversampling 1). When out_o stalls, the whole pipe
// holds: in_i.ready drops, nothing is lost or repeated.
// A zero temperature divisor gives zero outputs with fault 1; a zero
// pressure divisor gives zero outputs with fault 2.
module pressure_temperature_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptc_in_if.sink      in_i,
  ptc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------- config
  logic [63:0] cal_t_q, cal_pl_q;
  logic [31:0] cal_ps_q;
  logic [1:0]  oss_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q  <= '0;
      cal_pl_q <= '0;
      cal_ps_q <= '0;
      oss_q    <= 2'd1;
    end else if (wr_en) begin
      case (paddr[4:3])
        ptc_pkg::REG_CAL_T:  cal_t_q  <= pwdata;
        ptc_pkg::REG_CAL_PL: cal_pl_q <= pwdata;
        ptc_pkg::REG_CAL_PS: cal_ps_q <= pwdata[31:0];
        ptc_pkg::REG_OSS:    oss_q    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      ptc_pkg::REG_CAL_T:  prdata = cal_t_q;
      ptc_pkg::REG_CAL_PL: prdata = cal_pl_q;
      ptc_pkg::REG_CAL_PS: prdata = {32'd0, cal_ps_q};
      ptc_pkg::REG_OSS:    prdata = {62'd0, oss_q};
      default:             prdata = '0;
    endcase
  end

  // Unpack coefficients to 32-bit words (sign or zero extend).
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
  assign ac5 = {16'd0, cal_t_q[63:48]};
  assign ac6 = {16'd0, cal_t_q[47:32]};
  assign mc  = {{16{cal_t_q[31]}}, cal_t_q[31:16]};
  assign md  = {{16{cal_t_q[15]}}, cal_t_q[15:0]};
  assign ac1 = {{16{cal_pl_q[63]}}, cal_pl_q[63:48]};
  assign ac2 = {{16{cal_pl_q[47]}}, cal_pl_q[47:32]};
  assign ac3 = {{16{cal_pl_q[31]}}, cal_pl_q[31:16]};
  assign ac4 = {16'd0, cal_pl_q[15:0]};
  assign b1  = {{16{cal_ps_q[31]}}, cal_ps_q[31:16]};
  assign b2  = {{16{cal_ps_q[15]}}, cal_ps_q[15:0]};

  // ---------------------------------------------------------------- flow
  // One global advance: the pipe moves whenever the output slot is free
  // or being drained this cycle.
  logic out_v_q, adv;
  assign adv         = !out_v_q || out_o.ready;
  assign in_i.ready  = adv;

  // Stage 1: X1 = ((UT - AC6) * AC5) >> 15
  logic        v1_q;
  logic [31:0] x1_1_q, x1_1_d;
  logic [18:0] up_1_q;
  assign x1_1_d = ptc_pkg::asr(({16'd0, in_i.raw_temperature} - ac6) * ac5, 5'd15);

  // Stage 2: divisor, operand magnitudes and quotient sign
  logic        v2_q;
  logic [31:0] div_t, num_t, na_2_q, da_2_q;
  ptc_pkg::sb_temp_t sb2_q, sb2_d;
  always_comb begin
    div_t     = x1_1_q + md;
    num_t     = mc << 11;
    sb2_d.x1  = x1_1_q;
    sb2_d.up  = up_1_q;
    sb2_d.f1  = (div_t == 32'd0);
    sb2_d.neg = num_t[31] ^ div_t[31];
  end

  // Temperature divider and its sideband line
  logic [31:0] q1;
  logic        v_d1_q [ptc_pkg::DIV_STEPS];
  ptc_pkg::sb_temp_t sb_d1_q [ptc_pkg::DIV_STEPS];

  ptc_div u_div_t (
    .clk_i     (clk_i),
    .en_i      (adv),
    .dividend_i(na_2_q),
    .divisor_i (da_2_q),
    .quotient_o(q1)
  );

  // Stage 3: X2 with sign, B5 and B6
  logic        v3_q;
  logic [31:0] b5_3_q, b6_3_q, x2_t, b5_d;
  logic [18:0] up_3_q;
  logic        f1_3_q;
  ptc_pkg::sb_temp_t sb_t_end;
  assign sb_t_end = sb_d1_q[ptc_pkg::DIV_STEPS-1];
  assign x2_t     = sb_t_end.neg ? (32'd0 - q1) : q1;
  assign b5_d     = sb_t_end.x1 + x2_t;

  // Stage 4: B6 products
  logic        v4_q;
  logic [31:0] sq_4_q, x2a_4_q, x1b_4_q, b5_4_q;
  logic [18:0] up_4_q;
  logic        f1_4_q;

  // Stage 5: products with the square term
  logic        v5_q;
  logic [31:0] p1_5_q, p2_5_q, x2a_5_q, x1b_5_q, b5_5_q;
  logic [18:0] up_5_q;
  logic        f1_5_q;

  // Stage 6: B3 and the B4 multiplicand
  logic        v6_q;
  logic [31:0] b3_6_q, t_6_q, b5_6_q, b3_d, x3b_d;
  logic [18:0] up_6_q;
  logic        f1_6_q;
  assign b3_d  = ptc_pkg::asr((((ac1 << 2) + p1_5_q + x2a_5_q) << oss_q) + 32'd2, 5'd2);
  assign x3b_d = ptc_pkg::asr(x1b_5_q + p2_5_q + 32'd2, 5'd2);

  // Stage 7: B4 and B7
  logic        v7_q;
  logic [31:0] b4_7_q, b7_7_q, b5_7_q, b4prod;
  logic        f1_7_q;
  assign b4prod = ac4 * t_6_q;

  // Stage 8: choose the division form, check the pressure divisor
  logic        v8_q;
  logic [31:0] na_8_q, da_8_q;
  ptc_pkg::sb_press_t sb8_q, sb8_d;
  always_comb begin
    sb8_d.b5   = b5_7_q;
    sb8_d.f1   = f1_7_q;
    sb8_d.f2   = (b4_7_q == 32'd0);
    sb8_d.post = (b7_7_q >= ptc_pkg::SIGN_BIT);
  end

  logic [31:0] q2;
  logic        v_d2_q [ptc_pkg::DIV_STEPS];
  ptc_pkg::sb_press_t sb_d2_q [ptc_pkg::DIV_STEPS];

  ptc_div u_div_p (
    .clk_i     (clk_i),
    .en_i      (adv),
    .dividend_i(na_8_q),
    .divisor_i (da_8_q),
    .quotient_o(q2)
  );

  // Stage 9: undo the split form of the division
  logic        v9_q;
  logic [31:0] p_9_q;
  ptc_pkg::sb_press_t sb9_q, sb_p_end;
  assign sb_p_end = sb_d2_q[ptc_pkg::DIV_STEPS-1];

  // Stage 10: correction products
  logic        v10_q;
  logic [31:0] p_10_q, x1m_10_q, x2m_10_q, s_9;
  ptc_pkg::sb_press_t sb10_q;
  assign s_9 = ptc_pkg::asr(p_9_q, 5'd8);

  // Stage 11: scale the square and linear corrections
  logic        v11_q;
  logic [31:0] p_11_q, x1_11_q, x2_11_q;
  ptc_pkg::sb_press_t sb11_q;

  // Output register
  ptc_pkg::temp_t  temp_q;
  ptc_pkg::press_t press_q;
  logic [1:0]      fault_q;
  logic [31:0]     p_fin, t_fin;
  assign p_fin = p_11_q + ptc_pkg::asr(x1_11_q + x2_11_q + ptc_pkg::K_ROUND, 5'd4);
  assign t_fin = ptc_pkg::asr(sb11_q.b5 + 32'd8, 5'd4);

  // Valid bits (control, reset)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      v9_q <= 1'b0; v10_q <= 1'b0; v11_q <= 1'b0; out_v_q <= 1'b0;
      for (int k = 0; k < ptc_pkg::DIV_STEPS; k++) begin
        v_d1_q[k] <= 1'b0;
        v_d2_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v_d1_q[0] <= v2_q;
      v_d2_q[0] <= v8_q;
      for (int k = 1; k < ptc_pkg::DIV_STEPS; k++) begin
        v_d1_q[k] <= v_d1_q[k-1];
        v_d2_q[k] <= v_d2_q[k-1];
      end
      v3_q <= v_d1_q[ptc_pkg::DIV_STEPS-1];
      v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q;
      v9_q <= v_d2_q[ptc_pkg::DIV_STEPS-1];
      v10_q <= v9_q; v11_q <= v10_q;
      out_v_q <= v11_q;
    end
  end

  // Payload (no reset)
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_1_q <= x1_1_d;
      up_1_q <= in_i.raw_pressure;

      sb2_q  <= sb2_d;
      na_2_q <= num_t[31] ? (32'd0 - num_t) : num_t;
      da_2_q <= div_t[31] ? (32'd0 - div_t) : div_t;

      sb_d1_q[0] <= sb2_q;
      sb_d2_q[0] <= sb8_q;
      for (int k = 1; k < ptc_pkg::DIV_STEPS; k++) begin
        sb_d1_q[k] <= sb_d1_q[k-1];
        sb_d2_q[k] <= sb_d2_q[k-1];
      end

      b5_3_q <= b5_d;
      b6_3_q <= b5_d - ptc_pkg::B6_OFFSET;
      up_3_q <= sb_t_end.up;
      f1_3_q <= sb_t_end.f1;

      sq_4_q  <= ptc_pkg::asr(b6_3_q * b6_3_q, 5'd12);
      x2a_4_q <= ptc_pkg::asr(ac2 * b6_3_q, 5'd11);
      x1b_4_q <= ptc_pkg::asr(ac3 * b6_3_q, 5'd13);
      b5_4_q  <= b5_3_q;
      up_4_q  <= up_3_q;
      f1_4_q  <= f1_3_q;

      p1_5_q  <= ptc_pkg::asr(b2 * sq_4_q, 5'd11);
      p2_5_q  <= ptc_pkg::asr(b1 * sq_4_q, 5'd16);
      x2a_5_q <= x2a_4_q;
      x1b_5_q <= x1b_4_q;
      b5_5_q  <= b5_4_q;
      up_5_q  <= up_4_q;
      f1_5_q  <= f1_4_q;

      b3_6_q <= b3_d;
      t_6_q  <= x3b_d + ptc_pkg::B4_BIAS;
      b5_6_q <= b5_5_q;
      up_6_q <= up_5_q;
      f1_6_q <= f1_5_q;

      b4_7_q <= b4prod >> 15;
      b7_7_q <= ({13'd0, up_6_q} - b3_6_q) * (ptc_pkg::OSS_SCALE >> oss_q);
      b5_7_q <= b5_6_q;
      f1_7_q <= f1_6_q;

      sb8_q  <= sb8_d;
      na_8_q <= sb8_d.post ? b7_7_q : (b7_7_q << 1);
      da_8_q <= b4_7_q;

      p_9_q <= sb_p_end.post ? (q2 << 1) : q2;
      sb9_q <= sb_p_end;

      p_10_q   <= p_9_q;
      x1m_10_q <= s_9 * s_9;
      x2m_10_q <= ptc_pkg::K_LIN * p_9_q;
      sb10_q   <= sb9_q;

      p_11_q  <= p_10_q;
      x1_11_q <= ptc_pkg::asr(x1m_10_q * ptc_pkg::K_SQ, 5'd16);
      x2_11_q <= ptc_pkg::asr(x2m_10_q, 5'd16);
      sb11_q  <= sb10_q;

      // temperature fault wins over pressure fault
      if (sb11_q.f1) begin
        temp_q  <= '0;
        press_q <= '0;
        fault_q <= ptc_pkg::FAULT_TEMP;
      end else if (sb11_q.f2) begin
        temp_q  <= '0;
        press_q <= '0;
        fault_q <= ptc_pkg::FAULT_PRESS;
      end else begin
        temp_q  <= ptc_pkg::temp_t'(t_fin[27:0]);
        press_q <= ptc_pkg::press_t'(p_fin);
        fault_q <= ptc_pkg::FAULT_OK;
      end
    end
  end

  assign out_o.valid              = out_v_q;
  assign out_o.temperature_tenths = temp_q;
  assign out_o.pressure_pa        = press_q;
  assign out_o.fault_code         = fault_q;

  // ---------------------------------------------------------------- checks
`include "pressure_temperature_compensation_assert.svh"

  `PTC_ASSERT_NEVER(a_fault_code_range, out_v_q && fault_q != ptc_pkg::FAULT_OK && fault_q != ptc_pkg::FAULT_TEMP && fault_q != ptc_pkg::FAULT_PRESS)
  `PTC_ASSERT(a_fault_zeroes, out_v_q && fault_q != ptc_pkg::FAULT_OK |-> temp_q == '0 && press_q == '0)
  `PTC_ASSERT(a_stall_blocks_input, out_v_q && !out_o.ready |-> !in_i.ready)

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pressure/temperature compensation block.
// Depends on ptc_pkg, ptc_if and the block's RTL; nothing else.

module tb;

  // Bit-exact model of the compensation plus the queue of expected words.
  class comp_board;
    logic [63:0] cal_t, cal_pl;
    logic [31:0] cal_ps;
    logic [1:0]  oss;
    logic [27:0] exp_temp[$];
    logic [31:0] exp_press[$];
    logic [1:0]  exp_fault[$];
    int          errors;

    function new();
      cal_t = '0; cal_pl = '0; cal_ps = '0; oss = 2'd1; errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        ptc_pkg::REG_CAL_T:  cal_t = val;
        ptc_pkg::REG_CAL_PL: cal_pl = val;
        ptc_pkg::REG_CAL_PS: cal_ps = val[31:0];
        default:             oss = val[1:0];
      endcase
    endfunction

    function logic [31:0] sra(logic [31:0] x, int n);
      return 32'($signed(x) >>> n);
    endfunction

    function logic [31:0] sxt(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    // Compensate one raw pair and push the expected word.
    function void note_input(logic [15:0] ut, logic [18:0] up);
      logic [31:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2;
      logic [31:0] x1, x2, x3, dv, b5, b6, sq, b3, b4, b7, p;
      logic [63:0] wide;
      ac5 = {16'd0, cal_t[63:48]}; ac6 = {16'd0, cal_t[47:32]};
      mc = sxt(cal_t[31:16]);      md = sxt(cal_t[15:0]);
      ac1 = sxt(cal_pl[63:48]);    ac2 = sxt(cal_pl[47:32]);
      ac3 = sxt(cal_pl[31:16]);    ac4 = {16'd0, cal_pl[15:0]};
      b1 = sxt(cal_ps[31:16]);     b2 = sxt(cal_ps[15:0]);
      x1 = sra(({16'd0, ut} - ac6) * ac5, 15);
      dv = x1 + md;
      if (dv == 0) begin
        push(28'd0, 32'd0, ptc_pkg::FAULT_TEMP);
        return;
      end
      x2 = 32'($signed(mc << 11) / $signed(dv));
      b5 = x1 + x2;
      b6 = b5 - ptc_pkg::B6_OFFSET;
      sq = sra(b6 * b6, 12);
      x3 = sra(b2 * sq, 11) + sra(ac2 * b6, 11);
      b3 = sra(((ac1 * 4 + x3) << oss) + 2, 2);
      x3 = sra(sra(ac3 * b6, 13) + sra(b1 * sq, 16) + 2, 2);
      wide = {32'd0, ac4} * {32'd0, x3 + ptc_pkg::B4_BIAS};
      b4 = wide[31:0] >> 15;
      if (b4 == 0) begin
        push(28'd0, 32'd0, ptc_pkg::FAULT_PRESS);
        return;
      end
      b7 = ({13'd0, up} - b3) * (ptc_pkg::OSS_SCALE >> oss);
      if (b7 < ptc_pkg::SIGN_BIT) p = (b7 * 2) / b4;
      else p = (b7 / b4) * 2;
      x1 = sra(p, 8) * sra(p, 8);
      x1 = sra(x1 * ptc_pkg::K_SQ, 16);
      x2 = sra(ptc_pkg::K_LIN * p, 16);
      p = p + sra(x1 + x2 + ptc_pkg::K_ROUND, 4);
      x3 = sra(b5 + 8, 4);
      push(x3[27:0], p, ptc_pkg::FAULT_OK);
    endfunction

    function void push(logic [27:0] t, logic [31:0] p, logic [1:0] f);
      exp_temp.push_back(t); exp_press.push_back(p); exp_fault.push_back(f);
    endfunction

    function void check_result(logic [27:0] t, logic [31:0] p, logic [1:0] f);
      logic [27:0] et;
      logic [31:0] ep;
      logic [1:0]  ef;
      if (exp_temp.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      et = exp_temp.pop_front(); ep = exp_press.pop_front(); ef = exp_fault.pop_front();
      if (t !== et) begin
        $error("temperature_tenths expected %0h got %0h", et, t); errors++;
      end
      if (p !== ep) begin
        $error("pressure_pa expected %0h got %0h", ep, p); errors++;
      end
      if (f !== ef) begin
        $error("fault_code expected %0d got %0d", ef, f); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  ptc_in_if  in_if();
  ptc_out_if out_if();

  pressure_temperature_compensation dut (
    .clk_i, .rst_ni, .in_i(in_if.sink), .out_o(out_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  comp_board board = new();
  bit hold_rx = 1'b0;   // long receiver hold-off requested by the main flow
  bit sink_idle = 1'b1; // allow random receiver stalls when set

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.raw_temperature = '0;
    in_if.raw_pressure = '0;
    out_if.ready = 1'b0;
  end

  // Write one register: setup cycle, then access cycle; the model follows.
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.set_reg(idx, val);
  endtask

  // Offer one word, after a random gap when gaps is set; hold it until accepted.
  // Valid stays high after the accept so the next word can follow directly.
  task automatic send_word(logic [15:0] ut, logic [18:0] up, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.raw_temperature <= ut;
    in_if.raw_pressure <= up;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_input(ut, up);
  endtask

  // Drop valid, wait until every word has come back, then let the pipe drain.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.exp_temp.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Calibration sets close to a real sensor, so most words take the full path.
  task automatic load_typical(logic [1:0] o);
    logic [15:0] ac5, ac6, md;
    ac5 = 16'd24000 + 16'($urandom_range(0, 2000));
    ac6 = 16'd22000 + 16'($urandom_range(0, 2000));
    md  = 16'd2500 + 16'($urandom_range(0, 600));
    write_reg(ptc_pkg::REG_CAL_T, {ac5, ac6, 16'($signed(-11786)), md});
    write_reg(ptc_pkg::REG_CAL_PL, {16'd408, 16'($signed(-72)), 16'($signed(-14383)),
                                    16'd32741 + 16'($urandom_range(0, 500))});
    write_reg(ptc_pkg::REG_CAL_PS, {32'd0, 16'd6190, 16'd4});
    write_reg(ptc_pkg::REG_OSS, {62'd0, o});
  endtask

  // Receiver check: compare every accepted word with the model; the random stalls and long hold-off are driven below.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        board.check_result(out_if.temperature_tenths, out_if.pressure_pa,
                           out_if.fault_code);
    end
  end

  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      wait_n = sink_idle ? $urandom_range(0, 7) : 0;
      out_if.ready <= (wait_n == 0);
      @(posedge clk_i);
      if (wait_n != 0) begin
        repeat (wait_n - 1) @(posedge clk_i);
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset calibration: the temperature divisor is zero.
    send_word(16'd0, 19'd0, 0);
    send_word(16'hFFFF, 19'h7FFFF, 0);
    drain();

    // Typical calibration, field extremes.
    load_typical(2'd0);
    send_word(16'd27898, 19'd23843, 0);
    send_word(16'd0, 19'd0, 1);
    send_word(16'hFFFF, 19'h7FFFF, 1);
    send_word(16'h5555, 19'h2AAAA, 1);
    send_word(16'hAAAA, 19'h55555, 1);
    drain();

    // Temperature divisor zero: AC5 zero, MD zero.
    write_reg(ptc_pkg::REG_CAL_T, 64'h0000_1234_D1F6_0000);
    send_word(16'd1000, 19'd5000, 0);
    drain();
    // Pressure divisor zero: AC4 zero.
    load_typical(2'd3);
    write_reg(ptc_pkg::REG_CAL_PL, 64'h0198_FFB8_C7D1_0000);
    send_word(16'd27898, 19'd23843, 0);
    send_word(16'd30000, 19'h7FFFF, 0);
    drain();

    // Extreme calibration patterns.
    write_reg(ptc_pkg::REG_CAL_T, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(ptc_pkg::REG_CAL_PL, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(ptc_pkg::REG_CAL_PS, 64'h0000_0000_FFFF_FFFF);
    write_reg(ptc_pkg::REG_OSS, 64'd3);
    send_word(16'd0, 19'd0, 1);
    send_word(16'hFFFF, 19'h7FFFF, 1);
    drain();
    write_reg(ptc_pkg::REG_CAL_T, 64'h7FFF_8000_7FFF_8000);
    write_reg(ptc_pkg::REG_CAL_PL, 64'h8000_7FFF_8000_FFFF);
    write_reg(ptc_pkg::REG_CAL_PS, 64'h0000_0000_8000_7FFF);
    send_word(16'h8000, 19'h40000, 1);
    send_word(16'h7FFF, 19'h3FFFF, 1);
    drain();

    // Random phases; a long receiver hold-off in the first fills the pipe.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) begin
        write_reg(ptc_pkg::REG_CAL_T, {$urandom(), $urandom()});
        write_reg(ptc_pkg::REG_CAL_PL, {$urandom(), $urandom()});
        write_reg(ptc_pkg::REG_CAL_PS, {32'd0, $urandom()});
        write_reg(ptc_pkg::REG_OSS, {62'd0, 2'(ph)});
      end else begin
        load_typical(2'(ph));
      end
      if (ph == 0) hold_rx = 1'b1;
      sink_idle = (ph != 4);
      for (k = 0; k < 54; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_word(16'($urandom()), 19'($urandom()), ph != 5);
        else
          send_word(16'd25000 + 16'($urandom_range(0, 8000)),
                    19'($urandom_range(15000, 30000)) << ph[1:0], ph != 5);
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_if.sv
hw/rtl/ptc_div.sv
hw/rtl/pressure_temperature_compensation.sv
sim/tb.sv
